// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL of the gap penalty block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define AGP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define AGP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/agp_pkg.sv =====
// Package for the alignment gap penalty block: model codes, register
// indexes, stage structs, constants and small helper functions. No dependencies.
package agp_pkg;

    // penalty model codes
    localparam logic [1:0] MODEL_CDNA  = 2'd0;
    localparam logic [1:0] MODEL_TIGHT = 2'd1;
    localparam logic [1:0] MODEL_LOOSE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_GAP_MODEL  = 2'd0;
    localparam logic [1:0] REG_INTRON_MAX = 2'd1;

    localparam logic [27:0] INTRON_MAX_RST = 28'd750000;
    localparam logic [27:0] INTRON_BASE    = 28'd400000;

    // floor(d/3000) = (d * RECIP_3000) >> 40, exact for d < 2^28
    localparam logic [28:0] RECIP_3000 = 29'd366503876;
    // floor(d/2000) = (d * RECIP_2000) >> 39, exact for d < 2^28
    localparam logic [28:0] RECIP_2000 = 29'd274877907;

    localparam logic [31:0] SQUARE_MIN = 32'd48;
    localparam logic [31:0] DEC_MIN    = 32'd30;
    localparam logic [32:0] TIGHT_BASE = 33'd8;
    localparam logic [28:0] LOOSE_BASE = 29'd8;
    localparam logic [29:0] CDNA_BASE  = 30'd2;
    localparam logic [28:0] PEN_MAX    = 29'h1FFF_FFFF;

    localparam int EXP_N = 42;

    // least integer above e^k, k = 1..42
    localparam logic [60:0] EXP_CEIL [EXP_N] = '{
        61'd3, 61'd8, 61'd21, 61'd55, 61'd149, 61'd404, 61'd1097, 61'd2981,
        61'd8104, 61'd22027, 61'd59875, 61'd162755, 61'd442414, 61'd1202605,
        61'd3269018, 61'd8886111, 61'd24154953, 61'd65659970, 61'd178482301,
        61'd485165196, 61'd1318815735, 61'd3584912847, 61'd9744803447,
        61'd26489122130, 61'd72004899338, 61'd195729609429,
        61'd532048240602, 61'd1446257064292, 61'd3931334297145,
        61'd10686474581525, 61'd29048849665248, 61'd78962960182681,
        61'd214643579785917, 61'd583461742527455, 61'd1586013452313431,
        61'd4311231547115196, 61'd11719142372802612,
        61'd31855931757113757, 61'd86593400423993747,
        61'd235385266837019986, 61'd639843493530054950,
        61'd1739274941520501048
    };

    // operand stage
    typedef struct packed {
        logic [27:0] d1;       // h - 400000
        logic        long1;
        logic [27:0] d2;       // h - intron_max
        logic        long2;
        logic [31:0] hu;       // h, or -8h when negative
        logic        hu_neg;
        logic        hu_gt30;
        logic [28:0] nmag;     // -n
        logic        n_neg;
        logic [27:0] npos;     // n when non-negative
        logic        zero;
        logic [31:0] a1;       // a + 1
        logic [29:0] b1;       // b + 1
        logic [32:0] tight;
    } op_t;

    // product stage
    typedef struct packed {
        logic [16:0] q1;
        logic [17:0] q2;
        logic [62:0] hx;       // hu, squared when it came from a jump back above 48
        logic        hu_gt30;
        logic [28:0] nmag;
        logic        n_neg;
        logic [27:0] npos;
        logic        zero;
        logic [61:0] prod;
        logic [32:0] tight;
    } mul_t;

    // reduction stage
    typedef struct packed {
        logic [29:0] cdna_part;
        logic [4:0]  hl_half;
        logic [4:0]  n_add;
        logic        dec;
        logic [5:0]  k;
        logic        zero;
        logic [32:0] tight;
    } red_t;

    // bit length, zero for zero
    function automatic logic [6:0] bit_len(input logic [63:0] x);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
            begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [28:0] sat_pen(input logic [32:0] v);
        return (v > 33'(PEN_MAX)) ? PEN_MAX : v[28:0];
    endfunction

endpackage

// ===== rtl/core/alignment_gap_penalty_unit.sv =====
// Alignment gap penalty unit: five-register pipeline from gap pair to penalty.
// Depends on agp_pkg and assert_macros.svh.
//
// Usage
//   Input channel: h_gap / n_gap (29-bit signed) with in_valid / in_ready.
//   Output channel: penalty (29-bit unsigned) with out_valid / out_ready.
//   One penalty per accepted item, in order.
//   Config: cfg_we / cfg_index / cfg_data; index 0 gap_model, 1 intron_max.
//   Write it only while the pipeline is empty; the stages read it live.
// Timing
//   out_valid rises once an accepted item has passed the input, operand,
//   product, reduction and output registers in that order. Throughput is one
//   item per cycle while out_ready does not stall the output; the
//   product stage holds the 28x29 reciprocal multiplies, the 32x32 square and
//   the 32x30 log product, the reduction stage the bit-length encoders and
//   the 42 threshold compares.
// Stalls
//   Each stage advances when it is empty or the next one advances, so a
//   held out_ready fills the bubbles and then drops in_ready; no item is lost.
// Reset
//   Async active low: pipeline emptied, gap_model = cdna, intron_max = 750000.
`include "assert_macros.svh"

module alignment_gap_penalty_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [28:0] h_gap,
    input  logic signed [28:0] n_gap,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [28:0] penalty,
    input  logic               cfg_we,
    input  logic         [1:0] cfg_index,
    input  logic        [27:0] cfg_data
);

    // config
    logic [1:0]  gap_model_reg;
    logic [27:0] intron_max_reg;

    // stage valids
    logic in_vld_reg, op_vld_reg, mul_vld_reg, red_vld_reg, out_vld_reg;
    logic in_adv, op_adv, mul_adv, red_adv, out_adv;

    // stage payloads
    logic signed [28:0] h_reg, n_reg;
    agp_pkg::op_t  op_reg,  op_next;
    agp_pkg::mul_t mul_reg, mul_next;
    agp_pkg::red_t red_reg, red_next;
    logic [28:0]   penalty_reg, penalty_next;

    // operand stage temporaries
    logic [28:0] hmag, nmag;
    logic [29:0] np;
    logic [27:0] ov;
    logic        h_gt0, n_gt0;

    // product stage temporaries
    logic [56:0] q1p, q2p;
    logic [63:0] sq;
    logic [63:0] prod;

    // reduction stage temporaries
    logic [6:0]  bl_h, bl_n;
    logic [5:0]  kcnt;

    // output stage temporaries
    logic [31:0] cdna_sum;

    // ---------------- handshake / advance chain ----------------
    assign out_adv  = !out_vld_reg || out_ready;
    assign red_adv  = !red_vld_reg || out_adv;
    assign mul_adv  = !mul_vld_reg || red_adv;
    assign op_adv   = !op_vld_reg  || mul_adv;
    assign in_adv   = !in_vld_reg  || op_adv;
    assign in_ready = in_adv;

    assign out_valid = out_vld_reg;
    assign penalty   = penalty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            op_vld_reg     <= 1'b0;
            mul_vld_reg    <= 1'b0;
            red_vld_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
            gap_model_reg  <= agp_pkg::MODEL_CDNA;
            intron_max_reg <= agp_pkg::INTRON_MAX_RST;
        end
        else
        begin
            if (in_adv)  in_vld_reg  <= in_valid;
            if (op_adv)  op_vld_reg  <= in_vld_reg;
            if (mul_adv) mul_vld_reg <= op_vld_reg;
            if (red_adv) red_vld_reg <= mul_vld_reg;
            if (out_adv) out_vld_reg <= red_vld_reg;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    agp_pkg::REG_GAP_MODEL:  gap_model_reg  <= cfg_data[1:0];
                    agp_pkg::REG_INTRON_MAX: intron_max_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && in_valid)
        begin
            h_reg <= h_gap;
            n_reg <= n_gap;
        end
        if (op_adv)  op_reg      <= op_next;
        if (mul_adv) mul_reg     <= mul_next;
        if (red_adv) red_reg     <= red_next;
        if (out_adv) penalty_reg <= penalty_next;
    end

    // ---------------- operand stage ----------------
    // magnitudes of jump backs; -(-2^28) stays exact as a 29-bit unsigned
    assign hmag  = ~h_reg + 29'd1;
    assign nmag  = ~n_reg + 29'd1;
    assign h_gt0 = !h_reg[28] && (h_reg != '0);
    assign n_gt0 = !n_reg[28] && (n_reg != '0);
    assign np    = n_reg[28] ? {nmag, 1'b0} : {1'b0, n_reg};
    // overlap: shared part of two forward gaps
    assign ov    = (h_gt0 && n_gt0)
                 ? ((h_reg[27:0] < n_reg[27:0]) ? h_reg[27:0] : n_reg[27:0])
                 : 28'd0;

    always_comb
    begin
        op_next.d1      = h_reg[27:0] - agp_pkg::INTRON_BASE;
        op_next.long1   = !h_reg[28] && (h_reg[27:0] > agp_pkg::INTRON_BASE);
        op_next.d2      = h_reg[27:0] - intron_max_reg;
        op_next.long2   = !h_reg[28] && (h_reg[27:0] > intron_max_reg);
        op_next.hu      = h_reg[28] ? {hmag, 3'b000} : {3'b000, h_reg};
        op_next.hu_neg  = h_reg[28];
        op_next.hu_gt30 = op_next.hu > agp_pkg::DEC_MIN;
        op_next.nmag    = nmag;
        op_next.n_neg   = n_reg[28];
        op_next.npos    = n_reg[27:0];
        op_next.zero    = (h_reg == '0) && (n_reg == '0);
        op_next.a1      = op_next.hu - {4'd0, ov} + 32'd1;
        op_next.b1      = np - {2'd0, ov} + 30'd1;
        op_next.tight   = agp_pkg::TIGHT_BASE + 33'(op_next.hu) + 33'(np) - 33'(ov);
    end

    // ---------------- product stage ----------------
    assign q1p  = 57'(op_reg.d1) * 57'(agp_pkg::RECIP_3000);
    assign q2p  = 57'(op_reg.d2) * 57'(agp_pkg::RECIP_2000);
    assign sq   = 64'(op_reg.hu) * 64'(op_reg.hu);
    assign prod = 64'(op_reg.a1) * 64'(op_reg.b1);

    always_comb
    begin
        mul_next.q1      = op_reg.long1 ? q1p[56:40] : 17'd0;
        mul_next.q2      = (op_reg.long1 && op_reg.long2) ? q2p[56:39] : 18'd0;
        mul_next.hx      = (op_reg.hu_neg && (op_reg.hu > agp_pkg::SQUARE_MIN))
                         ? sq[62:0] : {31'd0, op_reg.hu};
        mul_next.hu_gt30 = op_reg.hu_gt30;
        mul_next.nmag    = op_reg.nmag;
        mul_next.n_neg   = op_reg.n_neg;
        mul_next.npos    = op_reg.npos;
        mul_next.zero    = op_reg.zero;
        mul_next.prod    = prod[61:0];
        mul_next.tight   = op_reg.tight;
    end

    // ---------------- reduction stage ----------------
    assign bl_h = agp_pkg::bit_len({1'b0, mul_reg.hx});
    assign bl_n = agp_pkg::bit_len({36'd0, mul_reg.npos});

    // thresholds rise with k, so the count of those passed is floor(ln(prod))
    always_comb
    begin
        kcnt = '0;
        for (int i = 0; i < agp_pkg::EXP_N; i++)
        begin
            if (mul_reg.prod >= {1'b0, agp_pkg::EXP_CEIL[i]})
            begin
                kcnt = kcnt + 6'd1;
            end
        end
    end

    always_comb
    begin
        red_next.cdna_part = agp_pkg::CDNA_BASE + 30'(mul_reg.q1) + 30'(mul_reg.q2)
                           + (mul_reg.n_neg ? 30'(mul_reg.nmag) : 30'd0);
        red_next.hl_half   = bl_h[5:1];
        // jump back in needle: magnitude already added, needle gap counts as 0
        red_next.n_add     = (!mul_reg.n_neg && (mul_reg.npos != '0)) ? bl_n[4:0] : 5'd0;
        red_next.dec       = (mul_reg.n_neg || (mul_reg.npos == '0)) && mul_reg.hu_gt30;
        red_next.k         = kcnt;
        red_next.zero      = mul_reg.zero;
        red_next.tight     = mul_reg.tight;
    end

    // ---------------- output stage ----------------
    assign cdna_sum = 32'(red_reg.cdna_part) + 32'(red_reg.hl_half)
                    + 32'(red_reg.n_add) - 32'(red_reg.dec);

    always_comb
    begin
        case (gap_model_reg)
            agp_pkg::MODEL_CDNA:  penalty_next = agp_pkg::sat_pen(33'(cdna_sum));
            agp_pkg::MODEL_TIGHT: penalty_next = red_reg.zero ? 29'd0
                                               : agp_pkg::sat_pen(red_reg.tight);
            agp_pkg::MODEL_LOOSE: penalty_next = red_reg.zero ? 29'd0
                                               : agp_pkg::LOOSE_BASE + 29'(red_reg.k);
            default:              penalty_next = 29'd0;
        endcase
    end

    // ---------------- assertions ----------------
    `AGP_ASSERT_NEXT(a_accept_captured, in_valid && in_ready, in_vld_reg, "accepted item not captured")
    `AGP_ASSERT_IMP(a_ready_when_empty, !in_vld_reg, in_ready, "input stage empty but not ready")
    `AGP_ASSERT_NEXT(a_op_stall_holds, op_vld_reg && !mul_adv, op_vld_reg && $stable(op_reg), "stalled operand stage changed")
    `AGP_ASSERT_NEXT(a_red_to_out, red_vld_reg && out_adv, out_valid, "reduced item did not reach output")
    `AGP_ASSERT_NEXT(a_zero_gaps, red_vld_reg && out_adv && red_reg.zero && gap_model_reg != agp_pkg::MODEL_CDNA, penalty == 29'd0, "zero gaps gave nonzero penalty")

endmodule

// ===== bench/alignment_gap_penalty_unit_tb.sv =====
// Self-checking bench for alignment_gap_penalty_unit: predicts each penalty from the gap pair
// and its own copy of the model registers, and compares results in order under random stalls.
// Depends on agp_pkg (model codes, register indexes, reset values) and the RTL of the block.
`timescale 1ns / 100ps

module alignment_gap_penalty_unit_tb;

    // Model code 3 has no model behind it; the block must answer zero.
    localparam logic [1:0] MODEL_SPARE = 2'd3;

    // cdna model constants
    localparam longint CDNA_START   = 2;
    localparam longint INTRON_FLOOR = 400000;   // first intron term starts above this
    localparam longint FLOOR_STEP   = 3000;
    localparam longint INTRON_STEP  = 2000;
    localparam longint SQUARE_ABOVE = 48;       // back jump above this gets squared
    localparam longint TRIM_ABOVE   = 30;       // no needle gap: drop one above this

    // tight / loose model constants
    localparam longint PEN_BASE    = 8;
    localparam longint HOP_SCALE   = 8;         // haystack back jump weighs 8x
    localparam longint NEEDLE_HOP  = 2;         // needle back jump weighs 2x
    localparam longint PEN_CEIL    = 536870911; // result saturates here

    // Least integer above e^k, k = 1..42: floor(ln(p)) = number of entries <= p.
    localparam int LN_STEPS = 42;
    localparam longint unsigned LN_EDGE [LN_STEPS] = '{
        64'd3, 64'd8, 64'd21, 64'd55, 64'd149, 64'd404, 64'd1097, 64'd2981,
        64'd8104, 64'd22027, 64'd59875, 64'd162755, 64'd442414, 64'd1202605,
        64'd3269018, 64'd8886111, 64'd24154953, 64'd65659970, 64'd178482301,
        64'd485165196, 64'd1318815735, 64'd3584912847, 64'd9744803447,
        64'd26489122130, 64'd72004899338, 64'd195729609429,
        64'd532048240602, 64'd1446257064292, 64'd3931334297145,
        64'd10686474581525, 64'd29048849665248, 64'd78962960182681,
        64'd214643579785917, 64'd583461742527455, 64'd1586013452313431,
        64'd4311231547115196, 64'd11719142372802612,
        64'd31855931757113757, 64'd86593400423993747,
        64'd235385266837019986, 64'd639843493530054950,
        64'd1739274941520501048
    };

    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int HOLD_PHASE      = 5;    // phase in which the receiver holds off
    localparam int HOLD_CYCLES     = 150;
    localparam int SETTLE_CYCLES   = 8;    // pipeline is 5 deep; a little margin

    typedef struct {
        logic [28:0] h;
        logic [28:0] n;
        logic [28:0] pen;
    } penalty_due_t;

    // Predicts penalties and holds them until the block answers.
    class gap_penalty_board;
        logic [1:0]   model;
        longint       intron_lim;
        penalty_due_t due_q[$];
        int           mismatch_count;

        function new();
            model          = agp_pkg::MODEL_CDNA;
            intron_lim     = longint'(agp_pkg::INTRON_MAX_RST);
            mismatch_count = 0;
        endfunction

        function void set_config(logic [1:0] m, logic [27:0] lim);
            model      = m;
            intron_lim = longint'(lim);
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function int bit_span(longint unsigned x);
            int w;
            w = 0;
            while (x != 0)
            begin
                w++;
                x >>= 1;
            end
            return w;
        endfunction

        function logic [28:0] predict_penalty(logic [28:0] h_raw, logic [28:0] n_raw);
            longint          h, n, acc, ov, a, b, p;
            longint unsigned hu, prod;
            int              k;
            h = $signed(h_raw);
            n = $signed(n_raw);
            case (model)
                agp_pkg::MODEL_CDNA:
                begin
                    acc = CDNA_START;
                    if (h > INTRON_FLOOR)
                    begin
                        acc += (h - INTRON_FLOOR) / FLOOR_STEP;
                        if (h > intron_lim)
                            acc += (h - intron_lim) / INTRON_STEP;
                    end
                    if (h < 0)
                    begin
                        hu = -HOP_SCALE * h;
                        if (hu > SQUARE_ABOVE)
                            hu = hu * hu;
                    end
                    else
                        hu = h;
                    if (n < 0)
                    begin
                        acc += -n;
                        n = 0;
                    end
                    acc += bit_span(hu) / 2;
                    if (n != 0)
                        acc += bit_span(n);
                    else if (hu > TRIM_ABOVE)
                        acc -= 1;
                    p = acc;
                end
                agp_pkg::MODEL_TIGHT, agp_pkg::MODEL_LOOSE:
                begin
                    if (h == 0 && n == 0)
                        p = 0;
                    else
                    begin
                        ov = (h < n) ? h : n;
                        if (ov < 0)
                            ov = 0;
                        if (h < 0)
                            h = -HOP_SCALE * h;
                        if (n < 0)
                            n = -NEEDLE_HOP * n;
                        a = h - ov;
                        b = n - ov;
                        if (model == agp_pkg::MODEL_TIGHT)
                            p = PEN_BASE + a + b + ov;
                        else
                        begin
                            prod = $unsigned(a + 1) * $unsigned(b + 1);
                            k = 0;
                            while (k < LN_STEPS && prod >= LN_EDGE[k])
                                k++;
                            p = PEN_BASE + k;
                        end
                    end
                end
                default: p = 0;
            endcase
            if (p < 0)
                p = 0;
            if (p > PEN_CEIL)
                p = PEN_CEIL;
            return p[28:0];
        endfunction

        function void note_gap_pair(logic [28:0] h, logic [28:0] n);
            penalty_due_t e;
            e.h   = h;
            e.n   = n;
            e.pen = predict_penalty(h, n);
            due_q.push_back(e);
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_penalty(logic [28:0] got);
            penalty_due_t e;
            if (due_q.size() == 0)
                report_mismatch($sformatf("penalty %0d with no item pending", got));
            else
            begin
                e = due_q.pop_front();
                if (got !== e.pen)
                    report_mismatch($sformatf("model %0d h %0d n %0d: penalty %0d, predicted %0d",
                        model, $signed(e.h), $signed(e.n), got, e.pen));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [28:0] h_gap;
    logic signed [28:0] n_gap;
    logic               out_valid;
    logic               out_ready;
    logic        [28:0] penalty;
    logic               cfg_we;
    logic         [1:0] cfg_index;
    logic        [27:0] cfg_data;

    gap_penalty_board board;

    int burst_left;     // items left in the current sender burst
    bit calm;           // no sender gaps in this phase
    bit hold_req;       // main flow asks the receiver for the long hold-off
    bit hold_done;
    int intron_now;     // current intron_max, to aim random gaps at its boundary

    alignment_gap_penalty_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .h_gap     (h_gap),
        .n_gap     (n_gap),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .penalty   (penalty),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Offer one gap pair and hold it until the block takes it. Valid stays high across
    // a burst; a burst ends with a random gap unless the phase is calm.
    task send_pair(input int h, input int n);
        int gap;
        in_valid <= 1'b1;
        h_gap    <= 29'(h);
        n_gap    <= 29'(n);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_gap_pair(29'(h), 29'(n));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering, wait for every pending penalty, then let the pipeline settle.
    task drain_pipe();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers back to back; junk in the unused upper bits of the model write.
    task write_config(input logic [1:0] model, input logic [27:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= agp_pkg::REG_GAP_MODEL;
        cfg_data  <= {26'($urandom()), model};
        @(posedge clk);
        cfg_index <= agp_pkg::REG_INTRON_MAX;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_config(model, lim);
        intron_now = int'(lim);
    endtask

    // Gap values: small ones, with aim at the intron boundaries, the extremes,
    // powers of two and full random patterns.
    function automatic int pick_gap(input int near);
        case ($urandom_range(0, 9))
            0, 1, 2: return int'($urandom_range(0, 200)) - 100;
            3:       return int'(INTRON_FLOOR) + int'($urandom_range(0, 8000)) - 4000;
            4:       return near + int'($urandom_range(0, 8000)) - 4000;
            5:
            begin
                case ($urandom_range(0, 3))
                    0:       return -268435456;
                    1:       return 268435455;
                    2:       return -16777216;
                    default: return -1;
                endcase
            end
            6, 7:    return int'($urandom());
            8:       return -int'($urandom_range(1, 100000));
            default: return (1 << $urandom_range(0, 27)) + int'($urandom_range(0, 2)) - 1;
        endcase
    endfunction

    // Receiver: runs of random length in one of four stall modes, plus one long
    // hold-off on request so the pipeline fills and in_ready drops.
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // Result side: every handshake on the output is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_penalty(penalty);
    end

    // Hard stop, well past the slowest legal run.
    initial
    begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        h_gap      = '0;
        n_gap      = '0;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = agp_pkg::REG_GAP_MODEL;
        cfg_data   = '0;
        burst_left = 3;
        calm       = 1'b0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        intron_now = int'(agp_pkg::INTRON_MAX_RST);
        board      = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cdna under the reset register values
        send_pair(0, 0);
        send_pair(30, 0);                   // at the trim threshold: no trim
        send_pair(31, 0);                   // just above: trimmed by one
        send_pair(-6, 5);                   // back jump lands on 48: not squared
        send_pair(-7, 0);                   // 56: squared
        send_pair(400000, 1);               // intron floor, no quotient yet
        send_pair(415001, 100);
        send_pair(750001, 0);               // just past intron_max
        send_pair(752000, 7);
        send_pair(268435455, 268435455);    // largest gaps
        send_pair(-268435456, -268435456);  // smallest gaps
        send_pair(-1, -1);
        send_pair(5, -16777216);

        // tight, intron_max at its low extreme
        drain_pipe();
        write_config(agp_pkg::MODEL_TIGHT, 28'd0);
        send_pair(0, 0);                    // zero gaps give zero
        send_pair(-268435456, 0);           // saturates
        send_pair(100, 40);                 // shared part
        send_pair(-5, -7);

        // loose: ln thresholds at the bottom and the top of the range
        drain_pipe();
        write_config(agp_pkg::MODEL_LOOSE, 28'd0);
        send_pair(0, 0);
        send_pair(1, 0);                    // product 2: below e
        send_pair(2, 0);                    // product 3: first threshold
        send_pair(-268435456, -268435456);
        send_pair(268435455, 0);

        // unused model code, intron_max at its high extreme
        drain_pipe();
        write_config(MODEL_SPARE, 28'hFFF_FFFF);
        send_pair(123, -4);
        send_pair(0, 0);

        // random phases: models cycle, intron_max walks through extremes and random values
        for (int phase = 0; phase < PHASES; phase++)
        begin
            logic [27:0] lim;
            drain_pipe();
            case (phase % 5)
                0:       lim = 28'd0;
                1:       lim = 28'hFFF_FFFF;
                2:       lim = agp_pkg::INTRON_MAX_RST;
                3:       lim = 28'($urandom_range(350000, 900000));
                default: lim = 28'($urandom());
            endcase
            write_config(2'(phase % 4), lim);
            calm = (phase % 3 == 0);
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_pair(pick_gap(intron_now), pick_gap(intron_now));
        end

        drain_pipe();
        if (board.mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
